// ===== src/tlpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared constants and types for the two-level page table engine.
// ----------------------------------------------------------------------------
package tlpt_pkg;

  localparam int ADDRESS_SPACES    = 4;
  localparam int TABLE_SLOTS       = 16;
  localparam int ENTRIES_PER_TABLE = 1024;

  localparam int IDX_W     = $clog2(ENTRIES_PER_TABLE);
  localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int NSLOT_W   = $clog2(TABLE_SLOTS + 1);
  localparam int DIR_DEPTH = ADDRESS_SPACES * ENTRIES_PER_TABLE;
  localparam int TBL_DEPTH = TABLE_SLOTS * ENTRIES_PER_TABLE;
  localparam int DIR_AW    = $clog2(DIR_DEPTH);
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int CLR_DEPTH = (DIR_DEPTH > TBL_DEPTH) ? DIR_DEPTH : TBL_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH) + 1;

  localparam logic [1:0] OP_MAP     = 2'd0;
  localparam logic [1:0] OP_UNMAP   = 2'd1;
  localparam logic [1:0] OP_PROTECT = 2'd2;
  localparam logic [1:0] OP_LOOKUP  = 2'd3;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_TABLE    = 2'd1;
  localparam logic [1:0] ST_NOT_PRESENT = 2'd2;
  localparam logic [1:0] ST_NO_SLOTS    = 2'd3;

  localparam int FLAG_PRESENT  = 0;
  localparam int FLAG_WRITABLE = 1;
  localparam int FLAG_USER     = 2;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              user;
    logic              present;
  } dir_ent_t;

  localparam int DENT_W = $bits(dir_ent_t);

endpackage

// ===== src/two_level_page_table_engine_core.sv =====
// ----------------------------------------------------------------------------
// two_level_page_table_engine_core
// Map/unmap/protect/lookup on two-level page tables held in block RAM.
// ----------------------------------------------------------------------------
// An accepted item passes through S_DIR and S_TBL; result_valid is registered in S_TBL.
// A new item is taken only when idle (directory read, dependent table read,
//   table write-back); busy is low again in the cycle the result shows.
// Reset: a clearing pass over max(directory, table) depth entries (16384 here)
//   zeroes both memories; busy stays high until it is done.
// Results cannot be stalled by the receiver.
module two_level_page_table_engine_core
  import tlpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [1:0]  space_id,
  input  logic [31:0] virtual_address,
  input  logic [31:0] physical_address,
  input  logic [11:0] entry_flags,
  input  logic        write_check,
  input  logic        user_check,
  output logic        result_valid,
  output logic [1:0]  status,
  output logic [31:0] translated_address,
  output logic        access_allowed,
  output logic [31:0] freed_frame,
  output logic [15:0] mapped_pages
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIR  = 2'd1;
  localparam logic [1:0] S_TBL  = 2'd2;

  dir_ent_t    dir_mem [DIR_DEPTH];
  logic [31:0] tbl_mem [TBL_DEPTH];

  logic [1:0]         state;
  logic               clearing;
  logic [CLR_W-1:0]   clr_cnt;
  logic [NSLOT_W-1:0] next_table_slot;
  logic [15:0]        page_count;

  logic [1:0]   op_q;
  logic [31:0]  va_q;
  logic [19:0]  frame_q;
  logic [11:0]  flags_q;
  logic         wr_q;
  logic         usr_q;
  logic [DIR_AW-1:0] dir_idx_q;

  dir_ent_t     dir_rdata;
  dir_ent_t     dent_q;
  logic         no_slots_q;
  logic [31:0]  tbl_rdata;
  logic [TBL_AW-1:0] tbl_idx_q;

  logic         accept;
  logic [1:0]   space_mod;
  logic [11:0]  dir_lin;
  logic [DIR_AW-1:0] dir_idx;

  // directory stage
  logic         need_table;
  logic         slots_full;
  dir_ent_t     dent_new;
  dir_ent_t     dent_eff;
  logic [TBL_AW-1:0] tbl_idx;

  // table stage
  logic [1:0]   status_next;
  logic [31:0]  xlat_next;
  logic         allowed_next;
  logic [31:0]  freed_next;
  logic [15:0]  page_count_next;
  logic         tbl_we;
  logic [31:0]  tbl_wdata;

  assign accept = start && !busy;
  assign busy   = clearing || (state != S_IDLE);
  assign mapped_pages = page_count;

  always_comb begin
    space_mod = space_id;
    for (int i = 0; i < 3; i++) begin
      if (int'(space_mod) >= ADDRESS_SPACES) begin
        space_mod = space_mod - 2'(ADDRESS_SPACES);
      end
    end
    dir_lin = {space_mod, virtual_address[31:22]};
    dir_idx = DIR_AW'(dir_lin);
  end

  always_comb begin
    need_table       = (op_q == OP_MAP) && !dir_rdata.present;
    slots_full       = next_table_slot >= NSLOT_W'(TABLE_SLOTS);
    dent_new.present = 1'b1;
    dent_new.user    = flags_q[FLAG_USER];
    dent_new.slot    = SLOT_W'(next_table_slot);
    dent_eff         = need_table ? dent_new : dir_rdata;
    tbl_idx          = TBL_AW'({dent_eff.slot, va_q[21:12]});
  end

  always_comb begin
    status_next     = ST_OK;
    xlat_next       = '0;
    allowed_next    = 1'b0;
    freed_next      = '0;
    page_count_next = page_count;
    tbl_we          = 1'b0;
    tbl_wdata       = {frame_q, flags_q};
    if (op_q == OP_MAP) begin
      if (no_slots_q) begin
        status_next = ST_NO_SLOTS;
      end else begin
        tbl_we = 1'b1;
        if (page_count != 16'hFFFF) begin
          page_count_next = page_count + 16'd1;
        end
      end
    end else if (!dent_q.present) begin
      status_next = ST_NO_TABLE;
    end else if (!tbl_rdata[FLAG_PRESENT]) begin
      status_next = ST_NOT_PRESENT;
    end else begin
      case (op_q)
        OP_UNMAP: begin
          freed_next = {tbl_rdata[31:12], 12'h000};
          tbl_we     = 1'b1;
          tbl_wdata  = '0;
          if (page_count != 16'd0) begin
            page_count_next = page_count - 16'd1;
          end
        end
        OP_PROTECT: begin
          tbl_we    = 1'b1;
          tbl_wdata = {tbl_rdata[31:12], flags_q};
        end
        default: begin
          xlat_next    = {tbl_rdata[31:12], va_q[11:0]};
          allowed_next = !(usr_q && !dent_q.user) &&
                         !(usr_q && !tbl_rdata[FLAG_USER]) &&
                         !(wr_q && !tbl_rdata[FLAG_WRITABLE]);
        end
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      clearing        <= 1'b1;
      clr_cnt         <= '0;
      next_table_slot <= '0;
      page_count      <= '0;
      result_valid    <= 1'b0;
    end else begin
      result_valid <= (state == S_TBL);
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == CLR_W'(CLR_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DIR;
          end
        end
        S_DIR: begin
          state <= S_TBL;
          if (need_table && !slots_full) begin
            next_table_slot <= next_table_slot + 1'b1;
          end
        end
        S_TBL: begin
          state      <= S_IDLE;
          page_count <= page_count_next;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= opcode;
      va_q      <= virtual_address;
      frame_q   <= physical_address[31:12];
      flags_q   <= entry_flags;
      wr_q      <= write_check;
      usr_q     <= user_check;
      dir_idx_q <= dir_idx;
    end
    if (state == S_DIR) begin
      dent_q     <= dent_eff;
      no_slots_q <= need_table && slots_full;
      tbl_idx_q  <= tbl_idx;
    end
    if (state == S_TBL) begin
      status             <= status_next;
      translated_address <= xlat_next;
      access_allowed     <= allowed_next;
      freed_frame        <= freed_next;
    end
  end

  // directory memory
  always_ff @(posedge clk) begin
    if (clearing) begin
      if (clr_cnt < CLR_W'(DIR_DEPTH)) begin
        dir_mem[clr_cnt[DIR_AW-1:0]] <= '0;
      end
    end else if (state == S_DIR && need_table && !slots_full) begin
      dir_mem[dir_idx_q] <= dent_new;
    end
    if (accept) begin
      dir_rdata <= dir_mem[dir_idx];
    end
  end

  // page table memory
  always_ff @(posedge clk) begin
    if (clearing) begin
      if (clr_cnt < CLR_W'(TBL_DEPTH)) begin
        tbl_mem[clr_cnt[TBL_AW-1:0]] <= '0;
      end
    end else if (state == S_TBL && tbl_we) begin
      tbl_mem[tbl_idx_q] <= tbl_wdata;
    end
    if (state == S_DIR) begin
      tbl_rdata <= tbl_mem[tbl_idx];
    end
  end

`ifndef SYNTHESIS
  a_result_after_table: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == S_TBL)
    else $error("result without table stage");

  a_accept_walks: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_DIR)
    else $error("accepted item did not start directory read");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    next_table_slot <= NSLOT_W'(TABLE_SLOTS))
    else $error("table slot counter overran pool");

  a_no_result_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !result_valid && state == S_IDLE)
    else $error("activity during clearing pass");

  a_no_slots_full: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == ST_NO_SLOTS) |-> next_table_slot == NSLOT_W'(TABLE_SLOTS))
    else $error("out of slots reported with free slots");
`endif

endmodule
